// File: src/chtb_pkg.sv
// ============================================================================
// chtb_pkg: shared definitions for the canonical Huffman table builder
// Field widths, operation and status codes, and the issue record that passes
// from the decision stage to the result stage.
// ============================================================================
package chtb_pkg;

    localparam int MAX_CODE_BITS_DEF = 16;
    localparam int SYMBOL_SLOTS_DEF  = 256;

    localparam int MODE_W   = 3;
    localparam int SYM_W    = 8;
    localparam int LEN_W    = 5;
    localparam int POS_W    = 8;
    localparam int CODE_W   = 16;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AT_POS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

    // Which table read, if any, completes the result in the second stage.
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_SYM  = 2'd1,
        SRC_POS  = 2'd2
    } src_t;

    typedef struct packed {
        src_t                src;
        logic [CODE_W-1:0]   code;
        logic [LEN_W-1:0]    len;
        logic [COUNT_W-1:0]  count;
        logic [SYM_W-1:0]    sym;
        logic [STATUS_W-1:0] status;
    } issue_t;

endpackage

// File: src/chtb_if.sv
// ============================================================================
// chtb_if: request and result channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ============================================================================
interface chtb_req_if;
    logic                          valid;
    logic                          ready;
    logic [chtb_pkg::MODE_W-1:0]   mode;
    logic [chtb_pkg::SYM_W-1:0]    symbol;
    logic [chtb_pkg::LEN_W-1:0]    code_length;
    logic [chtb_pkg::POS_W-1:0]    position;

    modport source (output valid, mode, symbol, code_length, position, input ready);
    modport sink   (input valid, mode, symbol, code_length, position, output ready);
endinterface

interface chtb_res_if;
    logic                          valid;
    logic                          ready;
    logic [chtb_pkg::CODE_W-1:0]   code;
    logic [chtb_pkg::LEN_W-1:0]    length_out;
    logic [chtb_pkg::COUNT_W-1:0]  count;
    logic [chtb_pkg::SYM_W-1:0]    symbol_out;
    logic [chtb_pkg::STATUS_W-1:0] status;

    modport source (output valid, code, length_out, count, symbol_out, status, input ready);
    modport sink   (input valid, code, length_out, count, symbol_out, status, output ready);
endinterface

// File: src/chtb_ram.sv
// ============================================================================
// chtb_ram: generic single-write, single-read RAM
// Registered read that updates only when the read enable is high.
// ============================================================================
module chtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/chtb_ctrl.sv
// ============================================================================
// chtb_ctrl: table state and per-request decision
// Holds the present bits, per-length counts and the running canonical code,
// decides each request and drives the table RAM ports.
// ============================================================================
module chtb_ctrl #(
    parameter int MAX_CODE_BITS = chtb_pkg::MAX_CODE_BITS_DEF,
    parameter int SYMBOL_SLOTS  = chtb_pkg::SYMBOL_SLOTS_DEF,
    localparam int IDX_W = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1,
    localparam int CW    = MAX_CODE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  logic [chtb_pkg::MODE_W-1:0]       mode,
    input  logic [chtb_pkg::SYM_W-1:0]        symbol,
    input  logic [chtb_pkg::LEN_W-1:0]        code_length,
    input  logic [chtb_pkg::POS_W-1:0]        position,
    output chtb_pkg::issue_t                  issue,
    output logic                              sym_wr_en,
    output logic [IDX_W-1:0]                  sym_addr,
    output logic [chtb_pkg::LEN_W+CW-1:0]     sym_wr_data,
    output logic                              pos_wr_en,
    output logic [IDX_W-1:0]                  pos_wr_addr,
    output logic [chtb_pkg::SYM_W+chtb_pkg::LEN_W+CW-1:0] pos_wr_data,
    output logic [IDX_W-1:0]                  pos_rd_addr
);

    localparam int TOT_W = $clog2(SYMBOL_SLOTS + 1);
    localparam int NC_W  = MAX_CODE_BITS + 1;
    localparam int CI_W  = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;
    localparam logic [chtb_pkg::SYM_W:0]   SLOT_LIM = (chtb_pkg::SYM_W + 1)'(SYMBOL_SLOTS);
    localparam logic [chtb_pkg::LEN_W-1:0] LEN_MAX  = chtb_pkg::LEN_W'(MAX_CODE_BITS);

    logic                          present_reg [SYMBOL_SLOTS];
    logic                          present_next [SYMBOL_SLOTS];
    logic [chtb_pkg::COUNT_W-1:0]  count_reg [MAX_CODE_BITS];
    logic [chtb_pkg::COUNT_W-1:0]  count_next [MAX_CODE_BITS];
    logic [NC_W-1:0]               next_code_reg, next_code_next;
    logic [chtb_pkg::LEN_W-1:0]    cur_len_reg, cur_len_next;
    logic [TOT_W-1:0]              total_reg, total_next;

    logic                          sym_in_range;
    logic                          present;
    logic                          len_ok;
    logic [CI_W-1:0]               cnt_idx;
    logic [chtb_pkg::LEN_W-1:0]    shamt;
    logic [NC_W-1:0]               cand;
    logic                          full;
    logic                          load_ok;
    logic                          clear;
    logic [chtb_pkg::COUNT_W-1:0]  bumped;

    assign sym_addr     = symbol[IDX_W-1:0];
    assign sym_in_range = {1'b0, symbol} < SLOT_LIM;
    assign present      = sym_in_range && present_reg[sym_addr];
    assign len_ok       = (code_length != '0) && (code_length <= LEN_MAX);
    assign cnt_idx      = CI_W'(code_length - chtb_pkg::LEN_W'(1));
    assign shamt        = code_length - cur_len_reg;
    // The running code never exceeds 2^current_length, so the shifted value fits.
    assign cand         = NC_W'(next_code_reg << shamt);
    assign full         = (cand >> code_length) != '0;
    assign bumped       = count_reg[cnt_idx] + chtb_pkg::COUNT_W'(1);

    always_comb
    begin
        issue        = '0;
        issue.src    = chtb_pkg::SRC_NONE;
        issue.status = chtb_pkg::ST_OK;
        load_ok      = 1'b0;
        clear        = 1'b0;
        case (mode)
            chtb_pkg::MODE_LOAD:
            begin
                if (!len_ok || (code_length < cur_len_reg))
                begin
                    issue.status = chtb_pkg::ST_ORDER;
                end
                else if (!sym_in_range || present)
                begin
                    issue.status = chtb_pkg::ST_MISS;
                end
                else if (full)
                begin
                    issue.status = chtb_pkg::ST_FULL;
                end
                else
                begin
                    load_ok     = 1'b1;
                    issue.code  = chtb_pkg::CODE_W'(cand);
                    issue.len   = code_length;
                    issue.count = bumped;
                    issue.sym   = symbol;
                end
            end
            chtb_pkg::MODE_LOOKUP:
            begin
                if (present)
                begin
                    issue.src = chtb_pkg::SRC_SYM;
                    issue.sym = symbol;
                end
                else
                begin
                    issue.status = chtb_pkg::ST_MISS;
                end
            end
            chtb_pkg::MODE_COUNT:
            begin
                if (len_ok)
                begin
                    issue.count = count_reg[cnt_idx];
                end
                else
                begin
                    issue.status = chtb_pkg::ST_MISS;
                end
            end
            chtb_pkg::MODE_AT_POS:
            begin
                if ((chtb_pkg::POS_W + 1)'(position) < (chtb_pkg::POS_W + 1)'(total_reg))
                begin
                    issue.src = chtb_pkg::SRC_POS;
                end
                else
                begin
                    issue.status = chtb_pkg::ST_MISS;
                end
            end
            chtb_pkg::MODE_CLEAR:
            begin
                clear = 1'b1;
            end
            default:
            begin
                issue.status = chtb_pkg::ST_MISS;
            end
        endcase
    end

    assign sym_wr_en   = fire && load_ok;
    assign sym_wr_data = {code_length, cand[CW-1:0]};
    assign pos_wr_en   = fire && load_ok;
    assign pos_wr_addr = total_reg[IDX_W-1:0];
    assign pos_wr_data = {symbol, code_length, cand[CW-1:0]};
    assign pos_rd_addr = position[IDX_W-1:0];

    always_comb
    begin
        present_next   = present_reg;
        count_next     = count_reg;
        next_code_next = next_code_reg;
        cur_len_next   = cur_len_reg;
        total_next     = total_reg;
        if (fire && clear)
        begin
            for (int i = 0; i < SYMBOL_SLOTS; i++)
            begin
                present_next[i] = 1'b0;
            end
            for (int j = 0; j < MAX_CODE_BITS; j++)
            begin
                count_next[j] = '0;
            end
            next_code_next = '0;
            cur_len_next   = chtb_pkg::LEN_W'(1);
            total_next     = '0;
        end
        else if (fire && load_ok)
        begin
            present_next[sym_addr] = 1'b1;
            count_next[cnt_idx]    = bumped;
            next_code_next         = cand + NC_W'(1);
            cur_len_next           = code_length;
            total_next             = total_reg + TOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SYMBOL_SLOTS; i++)
            begin
                present_reg[i] <= 1'b0;
            end
            for (int j = 0; j < MAX_CODE_BITS; j++)
            begin
                count_reg[j] <= '0;
            end
            next_code_reg <= '0;
            cur_len_reg   <= chtb_pkg::LEN_W'(1);
            total_reg     <= '0;
        end
        else
        begin
            present_reg   <= present_next;
            count_reg     <= count_next;
            next_code_reg <= next_code_next;
            cur_len_reg   <= cur_len_next;
            total_reg     <= total_next;
        end
    end

endmodule

// File: src/canonical_huffman_table_builder_core.sv
// ============================================================================
// canonical_huffman_table_builder_core: JPEG-style canonical Huffman table
// Loads symbols in order of code length, hands out canonical codes and answers
// code, per-length count and symbol-at-position queries.
// ============================================================================
// Pipeline: a request is decided and its table reads issued into the first stage; the
// output register takes the result. Throughput: one request per cycle unless the result
// channel stalls, with one registered read of the symbol- and position-indexed table RAMs.
// Reset: control state, present bits, counts, running code (zero) and current
// length (one) are cleared at once; the table RAMs are not cleared and need no
// clearing pass, since only entries written since the last clear are read.
module canonical_huffman_table_builder_core #(
    parameter int MAX_CODE_BITS = chtb_pkg::MAX_CODE_BITS_DEF,
    parameter int SYMBOL_SLOTS  = chtb_pkg::SYMBOL_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    chtb_req_if.sink   request,
    chtb_res_if.source result
);

    localparam int IDX_W     = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
    localparam int CW        = MAX_CODE_BITS;
    localparam int SYM_RAM_W = chtb_pkg::LEN_W + CW;
    localparam int POS_RAM_W = chtb_pkg::SYM_W + chtb_pkg::LEN_W + CW;

    // The first stage holds a decided request while its table read completes;
    // the second stage is the output register. Because the RAMs only update
    // their read data on a new transaction, a stalled first stage keeps its
    // read data intact.
    logic                 s1_valid_reg, s1_valid_next;
    chtb_pkg::issue_t     s1_issue_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 s1_adv;
    logic                 fire;

    logic [chtb_pkg::CODE_W-1:0]   code_reg, code_next;
    logic [chtb_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [chtb_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [chtb_pkg::SYM_W-1:0]    sym_reg, sym_next;
    logic [chtb_pkg::STATUS_W-1:0] status_reg, status_next;

    chtb_pkg::issue_t     issue;
    logic                 sym_wr_en;
    logic [IDX_W-1:0]     sym_addr;
    logic [SYM_RAM_W-1:0] sym_wr_data;
    logic [SYM_RAM_W-1:0] sym_rd_data;
    logic                 pos_wr_en;
    logic [IDX_W-1:0]     pos_wr_addr;
    logic [POS_RAM_W-1:0] pos_wr_data;
    logic [IDX_W-1:0]     pos_rd_addr;
    logic [POS_RAM_W-1:0] pos_rd_data;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !s1_valid_reg || s1_adv;
    assign fire          = request.valid && request.ready;

    chtb_ctrl #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .SYMBOL_SLOTS  (SYMBOL_SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .mode        (request.mode),
        .symbol      (request.symbol),
        .code_length (request.code_length),
        .position    (request.position),
        .issue       (issue),
        .sym_wr_en   (sym_wr_en),
        .sym_addr    (sym_addr),
        .sym_wr_data (sym_wr_data),
        .pos_wr_en   (pos_wr_en),
        .pos_wr_addr (pos_wr_addr),
        .pos_wr_data (pos_wr_data),
        .pos_rd_addr (pos_rd_addr)
    );

    // Code and length by symbol, for lookups.
    chtb_ram #(
        .WIDTH (SYM_RAM_W),
        .DEPTH (SYMBOL_SLOTS)
    ) u_sym_ram (
        .clk     (clk),
        .wr_en   (sym_wr_en),
        .wr_addr (sym_addr),
        .wr_data (sym_wr_data),
        .rd_en   (fire),
        .rd_addr (sym_addr),
        .rd_data (sym_rd_data)
    );

    // Symbol, code and length by load order, for position queries. Keeping the
    // code here too avoids a second dependent read through the symbol table.
    chtb_ram #(
        .WIDTH (POS_RAM_W),
        .DEPTH (SYMBOL_SLOTS)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (pos_wr_en),
        .wr_addr (pos_wr_addr),
        .wr_data (pos_wr_data),
        .rd_en   (fire),
        .rd_addr (pos_rd_addr),
        .rd_data (pos_rd_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Final result assembly: fold in the table read where the request needs one.
    always_comb
    begin
        code_next   = s1_issue_reg.code;
        len_next    = s1_issue_reg.len;
        count_next  = s1_issue_reg.count;
        sym_next    = s1_issue_reg.sym;
        status_next = s1_issue_reg.status;
        case (s1_issue_reg.src)
            chtb_pkg::SRC_SYM:
            begin
                code_next = chtb_pkg::CODE_W'(sym_rd_data[CW-1:0]);
                len_next  = sym_rd_data[CW +: chtb_pkg::LEN_W];
            end
            chtb_pkg::SRC_POS:
            begin
                code_next = chtb_pkg::CODE_W'(pos_rd_data[CW-1:0]);
                len_next  = pos_rd_data[CW +: chtb_pkg::LEN_W];
                sym_next  = pos_rd_data[CW + chtb_pkg::LEN_W +: chtb_pkg::SYM_W];
            end
            default:
            begin
                code_next = s1_issue_reg.code;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_issue_reg <= issue;
        end
        if (s1_adv)
        begin
            code_reg   <= code_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            sym_reg    <= sym_next;
            status_reg <= status_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.code       = code_reg;
    assign result.length_out = len_reg;
    assign result.count      = count_reg;
    assign result.symbol_out = sym_reg;
    assign result.status     = status_reg;

endmodule

// File: dv/canonical_huffman_table_builder_core_tb.sv
// ============================================================================
// canonical_huffman_table_builder_core_tb: self-checking bench for the table
// Drives load, lookup, count, position, clear and unused-mode requests through
// the request channel. A local model of the canonical code table predicts
// every result, and each result transaction is compared field by field with
// the oldest prediction. Both channels idle and stall at random.
// ============================================================================
module canonical_huffman_table_builder_core_tb;

    import chtb_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_GUARD    = 20000;
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_LEN        = MAX_CODE_BITS_DEF;
    localparam int SLOTS          = SYMBOL_SLOTS_DEF;

    // One request transaction as the block sees it.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  code_length;
        logic [POS_W-1:0]  position;
    } request_t;

    // One result transaction, in the order of the result channel's payload.
    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [LEN_W-1:0]    length_out;
        logic [COUNT_W-1:0]  count;
        logic [SYM_W-1:0]    symbol_out;
        logic [STATUS_W-1:0] status;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;

    chtb_req_if req_ch ();
    chtb_res_if res_ch ();

    canonical_huffman_table_builder_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Local copy of the code table. The per-symbol stores are only read for
    // symbols marked present or for positions below the loaded count, so a
    // clear only has to reset the marks, the counters, the running code and length.
    // ------------------------------------------------------------------------
    logic [CODE_W-1:0]  tbl_code  [SLOTS];
    logic [LEN_W-1:0]   tbl_len   [SLOTS];
    bit                 sym_present [SLOTS];
    logic [SYM_W-1:0]   sym_order [SLOTS];
    logic [COUNT_W-1:0] len_count [MAX_LEN];
    logic [CODE_W:0]    run_code;
    logic [LEN_W-1:0]   cur_len;
    logic [COUNT_W-1:0] loaded_count;

    // Predicted results, oldest first.
    table_result_t pending_results [$];

    int mismatches   = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    int rx_hold_left = 0;

    function automatic void huffman_table_clear();
        foreach (sym_present[i]) sym_present[i] = 1'b0;
        foreach (len_count[i]) len_count[i] = '0;
        run_code     = '0;
        cur_len      = LEN_W'(1);
        loaded_count = '0;
    endfunction

    // Applies one accepted request to the local table and returns the result
    // the block must produce for it. Any rejected request leaves the table as
    // it was, and a rejected result carries zeros in every field but status.
    function automatic table_result_t huffman_table_apply(request_t rq);
        table_result_t r;
        logic [31:0]   cand;
        logic [SYM_W-1:0] s;
        r = '0;
        r.status = ST_OK;
        case (rq.mode)
            MODE_LOAD:
            begin
                // The length check comes first, so a bad length wins over a
                // duplicate symbol.
                if (rq.code_length == 0 || rq.code_length > MAX_LEN ||
                    rq.code_length < cur_len)
                begin
                    r.status = ST_ORDER;
                end
                else if (sym_present[rq.symbol])
                begin
                    r.status = ST_MISS;
                end
                else
                begin
                    // Canonical rule: shift by the rise in length, then the
                    // shifted code must still fit in the new length.
                    cand = 32'(run_code) << (rq.code_length - cur_len);
                    if (cand >= (32'd1 << rq.code_length))
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        cur_len  = rq.code_length;
                        run_code = (CODE_W + 1)'(cand + 32'd1);
                        tbl_code[rq.symbol]    = cand[CODE_W-1:0];
                        tbl_len[rq.symbol]     = rq.code_length;
                        sym_present[rq.symbol] = 1'b1;
                        sym_order[loaded_count[SYM_W-1:0]] = rq.symbol;
                        loaded_count = loaded_count + 1'b1;
                        len_count[rq.code_length - 1] = len_count[rq.code_length - 1] + 1'b1;
                        r.code       = cand[CODE_W-1:0];
                        r.length_out = rq.code_length;
                        r.count      = len_count[rq.code_length - 1];
                        r.symbol_out = rq.symbol;
                    end
                end
            end
            MODE_LOOKUP:
            begin
                if (sym_present[rq.symbol])
                begin
                    r.code       = tbl_code[rq.symbol];
                    r.length_out = tbl_len[rq.symbol];
                    r.symbol_out = rq.symbol;
                end
                else
                begin
                    r.status = ST_MISS;
                end
            end
            MODE_COUNT:
            begin
                if (rq.code_length >= 1 && rq.code_length <= MAX_LEN)
                    r.count = len_count[rq.code_length - 1];
                else
                    r.status = ST_MISS;
            end
            MODE_AT_POS:
            begin
                if (rq.position < loaded_count)
                begin
                    s = sym_order[rq.position];
                    r.code       = tbl_code[s];
                    r.length_out = tbl_len[s];
                    r.symbol_out = s;
                end
                else
                begin
                    r.status = ST_MISS;
                end
            end
            MODE_CLEAR:
            begin
                huffman_table_clear();
            end
            default:
            begin
                r.status = ST_MISS;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch, and a running count.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // Every result transaction is checked against the oldest prediction. The
    // outputs are read in the active region right after the edge, so they
    // still hold the values the edge itself sampled.
    always @(posedge clk)
    begin : result_checker
        table_result_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request waiting", 32'(res_ch.status), 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("code",       32'(res_ch.code),       32'(want.code));
                check_field("length_out", 32'(res_ch.length_out), 32'(want.length_out));
                check_field("count",      32'(res_ch.count),      32'(want.count));
                check_field("symbol_out", 32'(res_ch.symbol_out), 32'(want.symbol_out));
                check_field("status",     32'(res_ch.status),     32'(want.status));
            end
        end
    end

    // Idle gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Result side. A forced hold, set by a test, is counted down here; apart
    // from that the ready line drops for random stretches when enabled.
    // ------------------------------------------------------------------------
    initial
    begin : result_ready_driver
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                res_ch.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Each call starts and returns right after a rising edge.
    // Valid stays high on return, so a following call with no gap keeps it
    // high without a second assignment in the same time step. The prediction
    // is made at the edge that accepts the transaction.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len, input logic [POS_W-1:0] pos);
        request_t rq;
        int       gap;
        rq  = '{mode: mode, symbol: sym, code_length: len, position: pos};
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.symbol      <= sym;
        req_ch.code_length <= len;
        req_ch.position    <= pos;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        pending_results.push_back(huffman_table_apply(rq));
    endtask

    // Lowers valid and waits until every predicted result has come back.
    // At least one edge always passes, so valid is never lowered and raised
    // in the same time step.
    task automatic wait_drain();
        int guard;
        req_ch.valid <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end while (pending_results.size() != 0 && guard < DRAIN_GUARD);
        if (pending_results.size() != 0)
        begin
            report_mismatch("results never delivered", 32'(pending_results.size()), 32'd0);
            pending_results.delete();
        end
    endtask

    function automatic logic [SYM_W-1:0] pick_absent_symbol();
        int start;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
            if (!sym_present[(start + k) % SLOTS])
                return SYM_W'((start + k) % SLOTS);
        return SYM_W'(start);
    endfunction

    // ------------------------------------------------------------------------
    // Directed cases: empty-table queries, bad lengths, the code space filling
    // at length one, duplicates, a falling length, the count and position
    // limits and the unused modes.
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        send_item(MODE_COUNT,  8'hFF, 5'd1,  8'h00);   // empty count is zero
        send_item(MODE_LOOKUP, 8'h00, 5'd0,  8'hFF);   // absent symbol
        send_item(MODE_AT_POS, 8'h00, 5'd0,  8'h00);   // nothing loaded yet
        send_item(MODE_LOAD,   8'h00, 5'd0,  8'h00);   // zero length
        send_item(MODE_LOAD,   8'h00, 5'd17, 8'h00);   // just above the longest code
        send_item(MODE_LOAD,   8'h00, 5'd31, 8'hFF);   // all length bits set
        send_item(MODE_LOAD,   8'h00, 5'd1,  8'h00);   // code 0
        send_item(MODE_LOAD,   8'hFF, 5'd1,  8'h00);   // code 1, length one now full
        send_item(MODE_LOAD,   8'h80, 5'd2,  8'h00);   // no room left at length two
        send_item(MODE_LOAD,   8'h00, 5'd1,  8'h00);   // duplicate symbol
        send_item(MODE_COUNT,  8'h00, 5'd1,  8'h00);
        send_item(MODE_AT_POS, 8'h00, 5'd0,  8'd1);
        send_item(MODE_CLEAR,  8'hFF, 5'd31, 8'hFF);
        send_item(MODE_LOAD,   8'h5A, 5'd3,  8'h00);
        send_item(MODE_LOAD,   8'hA5, 5'd2,  8'h00);   // length falls
        send_item(MODE_LOAD,   8'h33, 5'd16, 8'h00);   // large jump in length
        send_item(MODE_LOAD,   8'h34, 5'd16, 8'h00);
        send_item(MODE_LOOKUP, 8'h33, 5'd0,  8'h00);
        send_item(MODE_COUNT,  8'h00, 5'd16, 8'h00);
        send_item(MODE_COUNT,  8'h00, 5'd0,  8'h00);   // bad query lengths
        send_item(MODE_COUNT,  8'h00, 5'd17, 8'h00);
        send_item(MODE_AT_POS, 8'h00, 5'd0,  8'hFF);   // beyond the loaded list
        for (int m = MODE_CLEAR + 1; m < (1 << MODE_W); m++)
            send_item(MODE_W'(m), 8'hFF, 5'd31, 8'hFF);
        wait_drain();
    endtask

    // One code at each length from 1 to the longest, then the all-ones code,
    // then one more load that cannot fit anywhere.
    task automatic test_code_space_limits();
        int base;
        base = $urandom_range(0, SLOTS - 1);
        send_item(MODE_CLEAR, SYM_W'($urandom), LEN_W'($urandom), POS_W'($urandom));
        for (int l = 1; l <= MAX_LEN; l++)
            send_item(MODE_LOAD, SYM_W'(base + l), LEN_W'(l), POS_W'($urandom));
        send_item(MODE_LOAD,   SYM_W'(base + MAX_LEN + 1), LEN_W'(MAX_LEN), POS_W'($urandom));
        send_item(MODE_LOAD,   SYM_W'(base + MAX_LEN + 2), LEN_W'(MAX_LEN), POS_W'($urandom));
        send_item(MODE_LOOKUP, SYM_W'(base + MAX_LEN + 1), LEN_W'($urandom),
                  POS_W'($urandom));
        send_item(MODE_AT_POS, SYM_W'($urandom), LEN_W'($urandom), POS_W'(MAX_LEN));
        send_item(MODE_COUNT,  SYM_W'($urandom), LEN_W'(MAX_LEN), POS_W'($urandom));
        wait_drain();
    endtask

    // Every symbol loaded once at length eight in shuffled order, so the list
    // and a per-length count both reach their full size.
    task automatic test_full_alphabet();
        logic [SYM_W-1:0] order [SLOTS];
        logic [SYM_W-1:0] t;
        int               j;
        foreach (order[i]) order[i] = SYM_W'(i);
        for (int i = SLOTS - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        send_item(MODE_CLEAR, SYM_W'($urandom), LEN_W'($urandom), POS_W'($urandom));
        foreach (order[i])
            send_item(MODE_LOAD, order[i], LEN_W'(8), POS_W'($urandom));
        send_item(MODE_COUNT,  SYM_W'($urandom), LEN_W'(8), POS_W'($urandom));
        send_item(MODE_AT_POS, SYM_W'($urandom), LEN_W'($urandom), POS_W'(SLOTS - 1));
        // Every symbol is taken.
        send_item(MODE_LOAD,   SYM_W'($urandom), LEN_W'(9), POS_W'($urandom));
        send_item(MODE_LOOKUP, 8'hFF, LEN_W'($urandom), POS_W'($urandom));
        wait_drain();
    endtask

    // The result side holds off for a long stretch while requests keep
    // coming, so the block fills and stalls its request channel. The sender
    // then pauses until everything has drained.
    task automatic test_result_backpressure();
        tx_idle_on = 1'b0;
        send_item(MODE_CLEAR, SYM_W'($urandom), LEN_W'($urandom), POS_W'($urandom));
        rx_hold_left = 300;
        for (int i = 0; i < 48; i++)
        begin
            send_item(MODE_LOAD, SYM_W'(i * 5 + 1), LEN_W'(6 + i / 16), POS_W'($urandom));
            if (i % 4 == 3)
                send_item(MODE_LOOKUP, SYM_W'(i * 5 + 1), LEN_W'($urandom),
                          POS_W'($urandom));
        end
        wait_drain();
        tx_idle_on = 1'b1;
    endtask

    // Random tables: each round clears, then mostly loads symbols at
    // non-decreasing lengths with queries in between, plus a share of
    // broken loads and unused modes.
    task automatic test_random_tables(input int budget);
        int               sent;
        int               loads_left;
        int               target_len;
        int               roll;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] pos;
        sent = 0;
        while (sent < budget)
        begin
            send_item(MODE_CLEAR, SYM_W'($urandom), LEN_W'($urandom), POS_W'($urandom));
            sent++;
            target_len = $urandom_range(1, 6);
            loads_left = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 24)
                                                    : $urandom_range(25, 120);
            while (loads_left > 0 && sent < budget)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    // Move to a longer length mostly when the current one has
                    // no room left, sometimes just because; staying put on a
                    // full length now and then shows the saturation status.
                    if (target_len < MAX_LEN &&
                        (((int'(run_code) << (target_len - int'(cur_len))) >= (1 << target_len)
                          && $urandom_range(0, 3) != 0) || $urandom_range(0, 5) == 0))
                    begin
                        target_len = target_len + $urandom_range(1, 3);
                        if (target_len > MAX_LEN)
                            target_len = MAX_LEN;
                    end
                    send_item(MODE_LOAD, pick_absent_symbol(), LEN_W'(target_len),
                              POS_W'($urandom));
                    loads_left--;
                end
                else if (roll < 65)
                begin
                    if (loaded_count != 0 && $urandom_range(0, 3) != 0)
                        sym = sym_order[$urandom_range(0, loaded_count - 1)];
                    else
                        sym = SYM_W'($urandom);
                    send_item(MODE_LOOKUP, sym, LEN_W'($urandom), POS_W'($urandom));
                end
                else if (roll < 73)
                begin
                    if ($urandom_range(0, 1) == 0)
                        len = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
                    else
                        len = LEN_W'($urandom_range(1, MAX_LEN));
                    send_item(MODE_COUNT, SYM_W'($urandom), len, POS_W'($urandom));
                end
                else if (roll < 83)
                begin
                    if ($urandom_range(0, 3) == 0 || loaded_count >= SLOTS - 1)
                        pos = POS_W'($urandom);
                    else
                        pos = POS_W'($urandom_range(0, loaded_count + 1));
                    send_item(MODE_AT_POS, SYM_W'($urandom), LEN_W'($urandom), pos);
                end
                else if (roll < 95)
                begin
                    case ($urandom_range(0, 3))
                        0: send_item(MODE_LOAD, pick_absent_symbol(), '0, POS_W'($urandom));
                        1: send_item(MODE_LOAD, pick_absent_symbol(),
                                     LEN_W'($urandom_range(MAX_LEN + 1, (1 << LEN_W) - 1)),
                                     POS_W'($urandom));
                        2: send_item(MODE_LOAD, pick_absent_symbol(),
                                     (cur_len > 1) ? LEN_W'($urandom_range(1, cur_len - 1))
                                                   : LEN_W'(0),
                                     POS_W'($urandom));
                        default:
                        begin
                            // Duplicate of a loaded symbol at a legal length.
                            sym = (loaded_count != 0)
                                  ? sym_order[$urandom_range(0, loaded_count - 1)]
                                  : SYM_W'($urandom);
                            send_item(MODE_LOAD, sym, LEN_W'(target_len), POS_W'($urandom));
                        end
                    endcase
                end
                else
                begin
                    send_item(MODE_W'(MODE_CLEAR + $urandom_range(1, 3)),
                              SYM_W'($urandom), LEN_W'($urandom), POS_W'($urandom));
                end
                sent++;
            end
        end
        wait_drain();
    endtask

    // Random tables with both sides running flat out.
    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_tables(150);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin : test_sequence
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= MODE_LOAD;
        req_ch.symbol      <= '0;
        req_ch.code_length <= '0;
        req_ch.position    <= '0;
        huffman_table_clear();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_code_space_limits();
        test_full_alphabet();
        test_result_backpressure();
        test_back_to_back();
        test_random_tables(700);

        // Any stray result after the last one expected is caught here.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : run_timeout
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

endmodule
